/* src/sound_gain_fade_attenuator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the voice gain attenuator
// Concurrent check wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SOUND_GAIN_FADE_ATTENUATOR_MACROS_SVH
`define SOUND_GAIN_FADE_ATTENUATOR_MACROS_SVH

// same-cycle implication
`define SGFA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgfa: same-cycle check failed");

// next-cycle implication
`define SGFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgfa: next-cycle check failed");

`endif

/* src/sgfa_pkg.sv */
// ----------------------------------------------------------------------------
// sgfa_pkg
// Shared types, constants and the millibel table of the voice gain attenuator.
// ----------------------------------------------------------------------------
package sgfa_pkg;

    localparam int LEVEL_STEPS_DEF = 16;
    localparam int FADE_MICROS_DEF = 1500000;

    localparam int GAIN_W     = 32;
    localparam int CNT_W      = 6;
    localparam int SQ_STEPS   = 3;
    localparam int SQRT_STEPS = 25;
    localparam int DIV_STEPS  = 16;
    localparam int FDIV_STEPS = 4;

    localparam logic [2:0] REG_SOURCE_X   = 3'd0;
    localparam logic [2:0] REG_SOURCE_Y   = 3'd1;
    localparam logic [2:0] REG_SOURCE_Z   = 3'd2;
    localparam logic [2:0] REG_VOICE_GAIN = 3'd3;
    localparam logic [2:0] REG_ATTEN_NEAR = 3'd4;
    localparam logic [2:0] REG_ATTEN_FAR  = 3'd5;
    localparam logic [2:0] REG_SPATIAL    = 3'd6;

    localparam logic [1:0] FADE_NONE = 2'd0;
    localparam logic [1:0] FADE_IN   = 2'd1;
    localparam logic [1:0] FADE_DOWN = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ,
        OP_SQRT,
        OP_ATTSET,
        OP_DIV,
        OP_ATTMUL,
        OP_FMUL,
        OP_FDIV,
        OP_SAT,
        OP_LVL1,
        OP_LVL2,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] sel;
    } cmd_t;

    typedef struct packed {
        logic spatial;
    } status_t;

    function automatic logic signed [12:0] mb_of(input logic [3:0] idx);
        logic signed [12:0] r;
        case (idx)
            4'd0:    r = -13'sd4000;
            4'd1:    r = -13'sd3600;
            4'd2:    r = -13'sd3200;
            4'd3:    r = -13'sd2800;
            4'd4:    r = -13'sd2400;
            4'd5:    r = -13'sd2100;
            4'd6:    r = -13'sd1800;
            4'd7:    r = -13'sd1500;
            4'd8:    r = -13'sd1200;
            4'd9:    r = -13'sd1000;
            4'd10:   r = -13'sd800;
            4'd11:   r = -13'sd600;
            4'd12:   r = -13'sd400;
            4'd13:   r = -13'sd200;
            4'd14:   r = -13'sd100;
            default: r = 13'sd0;
        endcase
        return r;
    endfunction

endpackage

/* src/sound_gain_fade_attenuator.sv */
// ----------------------------------------------------------------------------
// sound_gain_fade_attenuator
// Per-voice gain with distance attenuation, fade envelope and millibel level.
// ----------------------------------------------------------------------------
// Usage:
//   Write source position, voice gain, attenuation distances and spatial mode
//   on the cfg channel (always ready) while no frame update is in flight.
//   Send one frame update per transfer on the s_ channel; one result per
//   update leaves on the m_ channel.
// Sequencing:
//   One update is in work at a time; s_tready is high only in idle. The
//   work is set by the shared sequential datapath: a 3-step distance sum,
//   a 25-step square root, a 16-step attenuation divider and a 4-step fade
//   scaling. With spatial mode off only the fade scaling and level run.
//   A new update is taken while the previous result still waits on m_.
// Reset:
//   Config registers return to their defaults, fade envelope at full gain, last
//   applied gain at unity, no result pending.
// Stall:
//   A held result stays on m_tdata; the next update finishes its work and
//   then waits until that result is taken.
// ----------------------------------------------------------------------------
`include "sound_gain_fade_attenuator_macros.svh"

module sound_gain_fade_attenuator #(
    parameter int LEVEL_STEPS = sgfa_pkg::LEVEL_STEPS_DEF,
    parameter int FADE_MICROS = sgfa_pkg::FADE_MICROS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // listener_x, listener_y, listener_z, category_gain, frame_micros,
    // fade_request, zero fill
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // level_millibel, mute, level_changed, stop_request
    output logic [15:0]  m_tdata
);

    sgfa_pkg::cmd_t    cmd;
    sgfa_pkg::status_t status;

    assign cfg_ready = 1'b1;

    sgfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sgfa_datapath #(
        .LEVEL_STEPS (LEVEL_STEPS),
        .FADE_MICROS (FADE_MICROS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata)
    );

    `SGFA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `SGFA_ASSERT_IMP(a_mute_floor, m_tvalid && m_tdata[13], m_tdata[12:0] == 13'h1060)
    `SGFA_ASSERT_IMP(a_stop_mutes, m_tvalid && m_tdata[15], m_tdata[13])
    `SGFA_ASSERT_IMP(a_level_nonpos, m_tvalid, m_tdata[12] || (m_tdata[12:0] == 13'd0))

endmodule

/* src/sgfa_ctrl.sv */
// ----------------------------------------------------------------------------
// sgfa_ctrl
// Sequencer: steps the datapath through one frame update and owns handshakes.
// ----------------------------------------------------------------------------
module sgfa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  sgfa_pkg::status_t  status,
    output sgfa_pkg::cmd_t     cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_SQ     = 12'b0000_0000_0010,
        S_SQRT   = 12'b0000_0000_0100,
        S_ATTSET = 12'b0000_0000_1000,
        S_DIV    = 12'b0000_0001_0000,
        S_ATTMUL = 12'b0000_0010_0000,
        S_FMUL   = 12'b0000_0100_0000,
        S_FDIV   = 12'b0000_1000_0000,
        S_SAT    = 12'b0001_0000_0000,
        S_LVL1   = 12'b0010_0000_0000,
        S_LVL2   = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } state_t;

    localparam logic [sgfa_pkg::CNT_W-1:0] SQ_LAST   =
        sgfa_pkg::CNT_W'(sgfa_pkg::SQ_STEPS - 1);
    localparam logic [sgfa_pkg::CNT_W-1:0] SQRT_LAST =
        sgfa_pkg::CNT_W'(sgfa_pkg::SQRT_STEPS - 1);
    localparam logic [sgfa_pkg::CNT_W-1:0] DIV_LAST  =
        sgfa_pkg::CNT_W'(sgfa_pkg::DIV_STEPS - 1);
    localparam logic [sgfa_pkg::CNT_W-1:0] FDIV_LAST =
        sgfa_pkg::CNT_W'(sgfa_pkg::FDIV_STEPS - 1);

    state_t                      state_reg, state_next;
    logic [sgfa_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        mvalid_reg, mvalid_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg + 1'b1;
        mvalid_next = mvalid_reg && !m_tready;
        s_tready    = 1'b0;
        cmd.op      = sgfa_pkg::OP_NONE;
        cmd.sel     = cnt_reg[1:0];
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cnt_next = '0;
                if (s_tvalid)
                begin
                    cmd.op     = sgfa_pkg::OP_LOAD;
                    state_next = status.spatial ? S_SQ : S_FMUL;
                end
            end
            S_SQ:
            begin
                cmd.op = sgfa_pkg::OP_SQ;
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.op = sgfa_pkg::OP_SQRT;
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = S_ATTSET;
                end
            end
            S_ATTSET:
            begin
                cmd.op     = sgfa_pkg::OP_ATTSET;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = sgfa_pkg::OP_DIV;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_ATTMUL;
                end
            end
            S_ATTMUL:
            begin
                cmd.op     = sgfa_pkg::OP_ATTMUL;
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                cmd.op     = sgfa_pkg::OP_FMUL;
                cnt_next   = '0;
                state_next = S_FDIV;
            end
            S_FDIV:
            begin
                cmd.op = sgfa_pkg::OP_FDIV;
                if (cnt_reg == FDIV_LAST)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                cmd.op     = sgfa_pkg::OP_SAT;
                state_next = S_LVL1;
            end
            S_LVL1:
            begin
                cmd.op     = sgfa_pkg::OP_LVL1;
                state_next = S_LVL2;
            end
            S_LVL2:
            begin
                cmd.op     = sgfa_pkg::OP_LVL2;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    cmd.op      = sgfa_pkg::OP_OUT;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

endmodule

/* src/sgfa_datapath.sv */
// ----------------------------------------------------------------------------
// sgfa_datapath
// Config registers, fade envelope, distance, attenuation, fade scaling, level.
// ----------------------------------------------------------------------------
module sgfa_datapath #(
    parameter int LEVEL_STEPS = sgfa_pkg::LEVEL_STEPS_DEF,
    parameter int FADE_MICROS = sgfa_pkg::FADE_MICROS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic [111:0]       in_data,
    input  sgfa_pkg::cmd_t     cmd,
    output sgfa_pkg::status_t  status,
    output logic [15:0]        out_data
);

    localparam int FW  = $clog2(FADE_MICROS + 1);
    localparam int EW  = ((FW > 20) ? FW : 20) + 1;
    localparam int GW  = sgfa_pkg::GAIN_W;
    localparam int PW  = GW + FW;
    localparam int XW  = FW + 15;
    localparam int MW  = XW + 17;
    localparam int FRW = FW + 1;
    localparam int LW  = $clog2(LEVEL_STEPS);
    localparam int VW  = 16 + LW;
    localparam logic [FW-1:0] FADE_FULL = FW'(FADE_MICROS);
    localparam logic [LW-1:0] LM1       = LW'(LEVEL_STEPS - 1);
    localparam logic [PW-1:0] SAT_LIM   = PW'(FADE_MICROS) << 30;
    localparam logic [16:0]   RECIP     = 17'((64'd1 << XW) / 64'(FADE_MICROS));

    logic signed [23:0] src_x_reg, src_y_reg, src_z_reg;
    logic [15:0]        vgain_reg;
    logic [23:0]        near_reg, far_reg;
    logic               spatial_reg;

    logic [1:0]         mode_reg;
    logic [FW-1:0]      fe_reg, fe_use_reg;
    logic [15:0]        applied_reg;
    logic               stop_reg;

    logic [GW-1:0]      gain_reg;
    logic signed [24:0] dx_reg, dy_reg, dz_reg;
    logic [49:0]        sq_reg;
    logic [26:0]        rem_reg;
    logic [24:0]        root_reg;
    logic               atten_reg;
    logic [24:0]        den_reg, dr_reg;
    logic [15:0]        fq_reg;
    logic [PW-1:0]      prod_reg;
    logic               fsat_reg;
    logic [XW-1:0]      x_reg;
    logic [15:0]        est_reg;
    logic [FRW-1:0]     frem_reg;
    logic [15:0]        g15_reg;
    logic               changed_reg;
    logic [VW-1:0]      v_reg;
    logic signed [12:0] a_reg;
    logic [23:0]        stp_reg;
    logic [15:0]        out_reg;

    logic signed [23:0] lx, ly, lz;
    logic [15:0]        cg;
    logic [19:0]        fm;
    logic [1:0]         fr;

    assign lx = in_data[23:0];
    assign ly = in_data[47:24];
    assign lz = in_data[71:48];
    assign cg = in_data[87:72];
    assign fm = in_data[107:88];
    assign fr = in_data[109:108];

    // fade envelope update
    logic [1:0]    mode_a;
    logic [FW-1:0] fe_a, fe_b;
    logic [EW-1:0] fe_sum, fe_ext, fm_ext;
    logic          stop_c;

    always_comb
    begin
        mode_a = mode_reg;
        fe_a   = fe_reg;
        if (fr == sgfa_pkg::FADE_IN && mode_reg != sgfa_pkg::FADE_IN)
        begin
            mode_a = sgfa_pkg::FADE_IN;
            fe_a   = '0;
        end
        else if (fr == sgfa_pkg::FADE_DOWN && mode_reg != sgfa_pkg::FADE_DOWN)
        begin
            mode_a = sgfa_pkg::FADE_DOWN;
            fe_a   = FADE_FULL;
        end
        fe_ext = EW'(fe_a);
        fm_ext = EW'(fm);
        fe_sum = fe_ext + fm_ext;
        if (mode_a == sgfa_pkg::FADE_IN)
        begin
            fe_b = (fe_sum > EW'(FADE_FULL)) ? FADE_FULL : fe_sum[FW-1:0];
        end
        else if (mode_a == sgfa_pkg::FADE_DOWN)
        begin
            fe_b = (fm_ext >= fe_ext) ? '0 : FW'(fe_ext - fm_ext);
        end
        else
        begin
            fe_b = fe_a;
        end
        stop_c = (fe_b == '0) && (mode_a == sgfa_pkg::FADE_DOWN);
    end

    // arithmetic helpers
    logic signed [24:0] dsel;
    logic signed [49:0] dsq;
    logic [28:0]        rs, trial;
    logic [24:0]        num, den_c;
    logic [23:0]        far_eff;
    logic [25:0]        dt;
    logic [47:0]        am;
    logic [PW-1:0]      fprod;
    logic [MW-1:0]      xr;
    logic [XW-1:0]      ef;
    logic [15:0]        g15_c;
    logic [LW:0]        k0, k1;
    logic [7:0]         k0e, k1e;
    logic [3:0]         i0, i1;
    logic signed [12:0] ta, tb, tdiff;
    logic [14:0]        frac;

    always_comb
    begin
        case (cmd.sel)
            2'd0:    dsel = dx_reg;
            2'd1:    dsel = dy_reg;
            default: dsel = dz_reg;
        endcase
        dsq     = dsel * dsel;
        rs      = {rem_reg, sq_reg[49:48]};
        trial   = {2'b00, root_reg, 2'b01};
        num     = root_reg - {1'b0, near_reg};
        far_eff = (far_reg < near_reg) ? near_reg : far_reg;
        den_c   = (far_eff == near_reg) ? 25'd256 : {1'b0, far_eff} - {1'b0, near_reg};
        dt      = {dr_reg, 1'b0};
        am      = 48'(gain_reg) * 48'(fq_reg);
        fprod   = PW'(gain_reg) * PW'(fe_use_reg);
        xr      = MW'(x_reg) * MW'(RECIP);
        ef      = XW'(est_reg) * XW'(FADE_FULL);
        g15_c   = fsat_reg ? 16'd32768 : est_reg;
        k0      = v_reg[VW-1:15];
        frac    = v_reg[14:0];
        k1      = (k0 < {1'b0, LM1}) ? k0 + 1'b1 : k0;
        k0e     = 8'(k0);
        k1e     = 8'(k1);
        i0      = (k0e > 8'd15) ? 4'd15 : k0e[3:0];
        i1      = (k1e > 8'd15) ? 4'd15 : k1e[3:0];
        ta      = sgfa_pkg::mb_of(i0);
        tb      = sgfa_pkg::mb_of(i1);
        tdiff   = tb - ta;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_x_reg   <= '0;
            src_y_reg   <= '0;
            src_z_reg   <= '0;
            vgain_reg   <= 16'd32768;
            near_reg    <= '0;
            far_reg     <= '0;
            spatial_reg <= 1'b0;
            mode_reg    <= sgfa_pkg::FADE_NONE;
            fe_reg      <= FADE_FULL;
            applied_reg <= 16'd32768;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sgfa_pkg::REG_SOURCE_X:   src_x_reg   <= cfg_data;
                    sgfa_pkg::REG_SOURCE_Y:   src_y_reg   <= cfg_data;
                    sgfa_pkg::REG_SOURCE_Z:   src_z_reg   <= cfg_data;
                    sgfa_pkg::REG_VOICE_GAIN: vgain_reg   <= cfg_data[15:0];
                    sgfa_pkg::REG_ATTEN_NEAR: near_reg    <= cfg_data;
                    sgfa_pkg::REG_ATTEN_FAR:  far_reg     <= cfg_data;
                    sgfa_pkg::REG_SPATIAL:    spatial_reg <= cfg_data[0];
                    default:                  ;
                endcase
            end
            if (cmd.op == sgfa_pkg::OP_LOAD)
            begin
                mode_reg <= stop_c ? sgfa_pkg::FADE_NONE : mode_a;
                fe_reg   <= stop_c ? FADE_FULL : fe_b;
            end
            if (cmd.op == sgfa_pkg::OP_OUT)
            begin
                applied_reg <= g15_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            sgfa_pkg::OP_LOAD:
            begin
                gain_reg   <= GW'(vgain_reg) * GW'(cg);
                dx_reg     <= {src_x_reg[23], src_x_reg} - {lx[23], lx};
                dy_reg     <= {src_y_reg[23], src_y_reg} - {ly[23], ly};
                dz_reg     <= {src_z_reg[23], src_z_reg} - {lz[23], lz};
                sq_reg     <= '0;
                rem_reg    <= '0;
                root_reg   <= '0;
                fe_use_reg <= fe_b;
                stop_reg   <= stop_c;
            end
            sgfa_pkg::OP_SQ:
            begin
                sq_reg <= sq_reg + $unsigned(dsq);
            end
            sgfa_pkg::OP_SQRT:
            begin
                sq_reg <= {sq_reg[47:0], 2'b00};
                if (rs >= trial)
                begin
                    rem_reg  <= 27'(rs - trial);
                    root_reg <= {root_reg[23:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rs[26:0];
                    root_reg <= {root_reg[23:0], 1'b0};
                end
            end
            sgfa_pkg::OP_ATTSET:
            begin
                atten_reg <= root_reg > {1'b0, near_reg};
                den_reg   <= den_c;
                dr_reg    <= (num >= den_c) ? '0 : den_c - num;
                fq_reg    <= '0;
            end
            sgfa_pkg::OP_DIV:
            begin
                if (dt >= {1'b0, den_reg})
                begin
                    dr_reg <= 25'(dt - {1'b0, den_reg});
                    fq_reg <= {fq_reg[14:0], 1'b1};
                end
                else
                begin
                    dr_reg <= dt[24:0];
                    fq_reg <= {fq_reg[14:0], 1'b0};
                end
            end
            sgfa_pkg::OP_ATTMUL:
            begin
                if (atten_reg)
                begin
                    gain_reg <= am[47:16];
                end
            end
            sgfa_pkg::OP_FMUL:
            begin
                prod_reg <= fprod;
            end
            sgfa_pkg::OP_FDIV:
            begin
                // scale by the fade length with a reciprocal estimate and one correction
                case (cmd.sel)
                    2'd0:
                    begin
                        fsat_reg <= prod_reg >= SAT_LIM;
                        x_reg    <= prod_reg[XW+14:15];
                    end
                    2'd1:
                    begin
                        est_reg <= xr[XW+15:XW];
                    end
                    2'd2:
                    begin
                        frem_reg <= FRW'(x_reg - ef);
                    end
                    default:
                    begin
                        if (frem_reg >= {1'b0, FADE_FULL})
                        begin
                            est_reg <= est_reg + 1'b1;
                        end
                    end
                endcase
            end
            sgfa_pkg::OP_SAT:
            begin
                g15_reg     <= g15_c;
                changed_reg <= g15_c != applied_reg;
            end
            sgfa_pkg::OP_LVL1:
            begin
                v_reg <= VW'(g15_reg) * VW'(LM1);
            end
            sgfa_pkg::OP_LVL2:
            begin
                a_reg   <= ta;
                stp_reg <= 24'(tdiff[8:0]) * 24'(frac);
            end
            sgfa_pkg::OP_OUT:
            begin
                out_reg <= {stop_reg, changed_reg, (g15_reg == 16'd0),
                            13'(a_reg + $signed({4'b0000, stp_reg[23:15]}))};
            end
            default:
            begin
            end
        endcase
    end

    assign status.spatial = spatial_reg;
    assign out_data       = out_reg;

endmodule
